// File: sv/pfmt_pkg.sv
// Package for the priority flow match table: item structs, codes, the per-cell
// entry, flag and command records and the field-match functions. No dependencies.
`default_nettype none
package pfmt_pkg;
	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_STRICT = 3'd1,
		OP_PACKET = 3'd2,
		OP_UPDATE = 3'd3,
		OP_DELETE = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EXISTS = 2'd1,
		ST_MISS   = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [21:0] wildcard_flags;
		logic [15:0] ingress_port;
		logic [47:0] eth_source;
		logic [47:0] eth_dest;
		logic [34:0] l2_tags;
		logic [13:0] ip_tos_proto;
		logic [31:0] ip_source;
		logic [31:0] ip_dest;
		logic [31:0] l4_ports;
		logic [15:0] rule_priority;
		logic [31:0] user_handle;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        hit;
		logic [31:0] result_handle;
	} out_item_t;

	// One stored entry; valid is held separately under reset.
	typedef struct packed {
		logic        exact;
		logic [21:0] wc;
		logic [15:0] port;
		logic [47:0] esrc;
		logic [47:0] edst;
		logic [34:0] l2;
		logic [13:0] tp;
		logic [31:0] isrc;
		logic [31:0] idst;
		logic [31:0] l4;
		logic [15:0] prio;
		logic [31:0] payload;
	} entry_t;

	// Per-cell compare flags handed to the resolver.
	typedef struct packed {
		logic strict_hit;
		logic exact_hit;
		logic wild_hit;
		logic lower_prio;
	} cell_flags_t;

	// Per-cell shift command from the control.
	typedef struct packed {
		logic load_new;
		logic take_lower;
		logic take_upper;
		logic set_payload;
		logic clear_valid;
	} cell_cmd_t;

	function automatic logic [31:0] prefix_mask(input logic [5:0] cnt);
		logic [31:0] m;
		m = (cnt >= 6'd32) ? 32'd0 : (32'hffff_ffff << cnt[4:0]);
		return m;
	endfunction

	function automatic logic fields_agree(input entry_t e, input in_item_t k,
		input logic [21:0] w);
		logic ok;
		ok = 1'b1;
		if (!w[0] && e.port != k.ingress_port) ok = 1'b0;
		if (!w[1] && e.l2[18:3] != k.l2_tags[18:3]) ok = 1'b0;
		if (!w[2] && e.esrc != k.eth_source) ok = 1'b0;
		if (!w[3] && e.edst != k.eth_dest) ok = 1'b0;
		if (!w[4] && e.l2[34:19] != k.l2_tags[34:19]) ok = 1'b0;
		if (!w[5] && e.tp[7:0] != k.ip_tos_proto[7:0]) ok = 1'b0;
		if (!w[6] && e.l4[31:16] != k.l4_ports[31:16]) ok = 1'b0;
		if (!w[7] && e.l4[15:0] != k.l4_ports[15:0]) ok = 1'b0;
		if (((e.isrc ^ k.ip_source) & prefix_mask(w[13:8])) != 32'd0) ok = 1'b0;
		if (((e.idst ^ k.ip_dest) & prefix_mask(w[19:14])) != 32'd0) ok = 1'b0;
		if (!w[20] && e.l2[2:0] != k.l2_tags[2:0]) ok = 1'b0;
		if (!w[21] && e.tp[13:8] != k.ip_tos_proto[13:8]) ok = 1'b0;
		return ok;
	endfunction
endpackage
`default_nettype wire

// File: sv/priority_flow_match_table.sv
// Top level of the priority flow match table: a row of slot cells plus the
// control that resolves hits and drives shifts. Depends on pfmt_pkg, pfmt_cell.
// An item accepted into req_q has its result registered into out_q in the
// cycle after. Items are taken one at a time; a new item is accepted at the
// edge the result leaves. The compare over all cells, the priority pick and
// the shift or payload write are all done in the busy_q work cycle.
// A stalled result holds off the next item.
// Reset clears every slot's valid bit and the control; entry data is not reset.
`default_nettype none
module priority_flow_match_table
	import pfmt_pkg::*;
#(
	parameter int ENTRIES = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data
);
	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	// The request is captured and held while the cells compare against it.
	in_item_t    req_q;
	logic        busy_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        valid_v [ENTRIES];
	entry_t      entry_v [ENTRIES];
	cell_flags_t flags_v [ENTRIES];
	cell_cmd_t   cmd_v   [ENTRIES];

	entry_t      ins_entry;
	logic        req_exact;

	// Resolution results.
	logic          strict_found, packet_found;
	logic [IW-1:0] strict_idx, packet_idx, pos_idx, hit_idx;
	logic          pos_found, hit_found;
	logic [CW-1:0] count;
	logic          full;
	out_item_t     result;

	assign req_exact = (req_q.wildcard_flags == 22'd0);
	// A result that leaves at this edge frees the block for the next item.
	assign in_stall  = busy_q || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		ins_entry.exact   = req_exact;
		ins_entry.wc      = req_q.wildcard_flags;
		ins_entry.port    = req_q.ingress_port;
		ins_entry.esrc    = req_q.eth_source;
		ins_entry.edst    = req_q.eth_dest;
		ins_entry.l2      = req_q.l2_tags;
		ins_entry.tp      = req_q.ip_tos_proto;
		ins_entry.isrc    = req_q.ip_source;
		ins_entry.idst    = req_q.ip_dest;
		ins_entry.l4      = req_q.l4_ports;
		ins_entry.prio    = req_exact ? 16'd0 : req_q.rule_priority;
		ins_entry.payload = req_q.user_handle;
	end

	// The row of cells. Each cell sees both neighbors for shifting up and down.
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		logic   lv, uv;
		entry_t le, ue;
		if (g == 0) begin : g_lo
			assign lv = 1'b0;
			assign le = ins_entry;
		end else begin : g_lo
			assign lv = valid_v[g-1];
			assign le = entry_v[g-1];
		end
		if (g == ENTRIES - 1) begin : g_hi
			assign uv = 1'b0;
			assign ue = ins_entry;
		end else begin : g_hi
			assign uv = valid_v[g+1];
			assign ue = entry_v[g+1];
		end
		pfmt_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.req         (req_q),
			.ins_entry   (ins_entry),
			.cmd         (cmd_v[g]),
			.lower_valid (lv),
			.lower_entry (le),
			.upper_valid (uv),
			.upper_entry (ue),
			.valid       (valid_v[g]),
			.entry       (entry_v[g]),
			.flags       (flags_v[g])
		);
	end

	// Priority pick: lowest cell wins, but an exact request's exact hit goes first.
	// Valid slots are always a prefix; the fill count is the first empty cell's index.
	always_comb begin
		logic ef;
		strict_found = 1'b0; strict_idx = '0;
		pos_found = 1'b0;    pos_idx = '0;
		count = CW'(ENTRIES);
		ef = 1'b0; packet_found = 1'b0; packet_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (flags_v[i].strict_hit) begin
				strict_found = 1'b1; strict_idx = IW'(i);
			end
			if (flags_v[i].lower_prio) begin
				pos_found = 1'b1; pos_idx = IW'(i);
			end
			if (!valid_v[i]) count = CW'(i);
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (flags_v[i].wild_hit) begin
				packet_found = 1'b1; packet_idx = IW'(i);
			end
		end
		if (req_exact) begin
			for (int i = ENTRIES - 1; i >= 0; i--) begin
				if (flags_v[i].exact_hit) begin
					ef = 1'b1; packet_idx = IW'(i);
				end
			end
		end
		if (ef) packet_found = 1'b1;
		full = (count == CW'(ENTRIES));
		if (req_q.operation == OP_PACKET) begin
			hit_found = packet_found; hit_idx = packet_idx;
		end else begin
			hit_found = strict_found; hit_idx = strict_idx;
		end
	end

	// Shift commands and the result for the item being worked on.
	always_comb begin
		logic          do_ins, do_del, do_upd;
		logic [CW-1:0] ins_at;
		result = '0;
		do_ins = 1'b0; do_del = 1'b0; do_upd = 1'b0;
		ins_at = count;
		if (!req_exact && pos_found) ins_at = CW'(pos_idx);
		case (req_q.operation)
			OP_INSERT: begin
				if (strict_found) result.status = ST_EXISTS;
				else if (full) result.status = ST_FULL;
				else do_ins = 1'b1;
			end
			OP_STRICT, OP_PACKET, OP_DELETE: begin
				if (!hit_found) begin
					result.status = ST_MISS;
				end else begin
					result.hit = 1'b1;
					result.result_handle = entry_v[hit_idx].payload;
					do_del = (req_q.operation == OP_DELETE);
				end
			end
			OP_UPDATE: begin
				if (!strict_found) result.status = ST_MISS;
				else do_upd = 1'b1;
			end
			default: result = '0;
		endcase
		for (int i = 0; i < ENTRIES; i++) begin
			cmd_v[i] = '0;
			if (busy_q) begin
				cmd_v[i].load_new    = do_ins && (CW'(i) == ins_at);
				cmd_v[i].take_lower  = do_ins && (CW'(i) > ins_at) && (CW'(i) <= count);
				cmd_v[i].take_upper  = do_del && (IW'(i) >= hit_idx)
					&& (CW'(i) + CW'(1) < count);
				cmd_v[i].clear_valid = do_del && (CW'(i) + CW'(1) == count);
				cmd_v[i].set_payload = do_upd && (IW'(i) == strict_idx);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) req_q <= in_data;
		if (busy_q) out_q <= result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) busy_q <= 1'b1;
			else if (busy_q) busy_q <= 1'b0;
			if (busy_q) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// The table's valid cells stay a contiguous prefix.
	for (genvar g = 1; g < ENTRIES; g++) begin : g_chk
		a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
			valid_v[g] |-> valid_v[g-1])
			else $error("valid slots not contiguous");
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && out_valid_q))
		else $error("work and pending result overlap");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> out_valid_q)
		else $error("result missing after work cycle");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && result.status == ST_FULL) |-> full)
		else $error("full reported with free slots");
endmodule
`default_nettype wire

// File: sv/pfmt_cell.sv
// One slot of the flow table: holds an entry, compares it to the request and
// shifts to or from its neighbors. Depends on pfmt_pkg.
`default_nettype none
module pfmt_cell
	import pfmt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire in_item_t    req,
	input  wire entry_t      ins_entry,
	input  wire cell_cmd_t   cmd,
	input  wire logic        lower_valid,
	input  wire entry_t      lower_entry,
	input  wire logic        upper_valid,
	input  wire entry_t      upper_entry,
	output logic             valid,
	output entry_t           entry,
	output cell_flags_t      flags
);
	logic   valid_q;
	entry_t entry_q;
	logic   req_exact;

	assign valid = valid_q;
	assign entry = entry_q;
	assign req_exact = (req.wildcard_flags == 22'd0);

	always_comb begin
		flags.strict_hit = valid_q && (entry_q.exact == req_exact)
			&& (entry_q.wc == req.wildcard_flags)
			&& (req_exact || entry_q.prio == req.rule_priority)
			&& fields_agree(entry_q, req, req.wildcard_flags);
		flags.exact_hit = valid_q && entry_q.exact && (entry_q.wc == 22'd0)
			&& fields_agree(entry_q, req, 22'd0);
		flags.wild_hit = valid_q && !entry_q.exact
			&& fields_agree(entry_q, req, entry_q.wc);
		flags.lower_prio = valid_q && !entry_q.exact
			&& (entry_q.prio < req.rule_priority);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.load_new) begin
			valid_q <= 1'b1;
		end else if (cmd.take_lower) begin
			valid_q <= lower_valid;
		end else if (cmd.take_upper) begin
			valid_q <= upper_valid;
		end else if (cmd.clear_valid) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_new) begin
			entry_q <= ins_entry;
		end else if (cmd.take_lower) begin
			entry_q <= lower_entry;
		end else if (cmd.take_upper) begin
			entry_q <= upper_entry;
		end else if (cmd.set_payload) begin
			entry_q.payload <= req.user_handle;
		end
	end
endmodule
`default_nettype wire
